// File: sv/bbcp_pkg.sv
package bbcp_pkg;

   // Largest bitmap dimension; larger register values saturate to this.
   localparam int unsigned MAX_DIMENSION = 4096;
   localparam int unsigned DIM_W         = 13;
   localparam int unsigned SCREEN_W      = 14;
   localparam int unsigned COORD_W       = 16;
   localparam int unsigned PITCH_W       = 16;
   localparam int unsigned LAYOUT_W      = 30;
   localparam int unsigned LAYOUT_FLD_W  = 5;
   localparam int unsigned CHANNEL_BITS  = 8;
   localparam int unsigned NUM_CHANNELS  = 3;
   localparam int unsigned WORD_W        = 32;

   // Destination pixels are 32-bit words: byte offset of a column is col << 2.
   localparam int unsigned BPP_SHIFT     = 2;

   localparam int unsigned CSR_ADDR_W    = 5;
   localparam int unsigned CSR_DATA_W    = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH    = 3'd0,
      REG_IMAGE_HEIGHT   = 3'd1,
      REG_DEST_X         = 3'd2,
      REG_DEST_Y         = 3'd3,
      REG_SCREEN_WIDTH   = 3'd4,
      REG_SCREEN_HEIGHT  = 3'd5,
      REG_ROW_PITCH      = 3'd6,
      REG_CHANNEL_LAYOUT = 3'd7
   } csr_index_type;

endpackage

// File: sv/bbcp_pack.sv
module bbcp_pack (
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] red_byte,
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] green_byte,
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] blue_byte,
   input  logic [bbcp_pkg::LAYOUT_W-1:0]     channel_layout,
   output logic [bbcp_pkg::WORD_W-1:0]       packed_pixel
);
   import bbcp_pkg::*;

   logic [CHANNEL_BITS-1:0] chan_byte [NUM_CHANNELS];

   assign chan_byte[0] = red_byte;
   assign chan_byte[1] = green_byte;
   assign chan_byte[2] = blue_byte;

   // Cut each channel to its mask size (keep the high bits), then place it.
   always_comb begin
      logic [LAYOUT_FLD_W-1:0] size;
      logic [LAYOUT_FLD_W-1:0] shift;
      logic [3:0]              size_sat;
      logic [3:0]              drop;
      logic [CHANNEL_BITS-1:0] kept;
      packed_pixel = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         size  = channel_layout[LAYOUT_FLD_W*i +: LAYOUT_FLD_W];
         shift = channel_layout[LAYOUT_FLD_W*(i+NUM_CHANNELS) +: LAYOUT_FLD_W];
         if (size > LAYOUT_FLD_W'(CHANNEL_BITS)) begin
            size_sat = 4'(CHANNEL_BITS);
         end else begin
            size_sat = size[3:0];
         end
         drop = 4'(CHANNEL_BITS) - size_sat;
         kept = chan_byte[i] >> drop;
         packed_pixel = packed_pixel | (WORD_W'(kept) << shift);
      end
   end

endmodule

// File: sv/bitmap_blit_clip_pack.sv
// Bitmap blit with clipping and RGB packing. Feed the pixels of a bottom-up
// bitmap in storage order, one transfer per pixel, with req_first_pixel set on
// the first stored pixel. Column and stored-row counters place each pixel; the
// stored row is flipped so the last stored row lands on the top screen row.
// Pixels outside screen_width x screen_height are dropped (counters still
// advance); each kept pixel gives one rsp transfer with the byte offset
// (dest_y+height-1-row)*row_pitch + (dest_x+col)*4 and the packed 32-bit word.
// One pixel is accepted every cycle unless rsp_stall holds a full pipeline:
// stage one places, clips and packs, stage two does the 14x16 pitch multiply
// and the add into the output register. Program the CSRs only while idle.
module bitmap_blit_clip_pack (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bbcp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bbcp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bbcp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] req_blue_byte,
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] req_green_byte,
   input  logic [bbcp_pkg::CHANNEL_BITS-1:0] req_red_byte,
   input  logic                              req_first_pixel,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bbcp_pkg::WORD_W-1:0]       rsp_byte_offset,
   output logic [bbcp_pkg::WORD_W-1:0]       rsp_packed_pixel,
   output logic                              rsp_last_pixel
);
   import bbcp_pkg::*;

   localparam int unsigned XY_W   = COORD_W + 2;          // signed placement math
   localparam int unsigned PROD_W = SCREEN_W + PITCH_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]    image_width_ff;
   logic [DIM_W-1:0]    image_height_ff;
   logic [COORD_W-1:0]  dest_x_ff;
   logic [COORD_W-1:0]  dest_y_ff;
   logic [SCREEN_W-1:0] screen_width_ff;
   logic [SCREEN_W-1:0] screen_height_ff;
   logic [PITCH_W-1:0]  row_pitch_ff;
   logic [LAYOUT_W-1:0] channel_layout_ff;

   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= '0;
         image_height_ff   <= '0;
         dest_x_ff         <= '0;
         dest_y_ff         <= '0;
         screen_width_ff   <= '0;
         screen_height_ff  <= '0;
         row_pitch_ff      <= '0;
         channel_layout_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:    image_width_ff    <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:   image_height_ff   <= csr_pwdata[DIM_W-1:0];
            REG_DEST_X:         dest_x_ff         <= csr_pwdata[COORD_W-1:0];
            REG_DEST_Y:         dest_y_ff         <= csr_pwdata[COORD_W-1:0];
            REG_SCREEN_WIDTH:   screen_width_ff   <= csr_pwdata[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT:  screen_height_ff  <= csr_pwdata[SCREEN_W-1:0];
            REG_ROW_PITCH:      row_pitch_ff      <= csr_pwdata[PITCH_W-1:0];
            REG_CHANNEL_LAYOUT: channel_layout_ff <= csr_pwdata[LAYOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:    csr_prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT:   csr_prdata = CSR_DATA_W'(image_height_ff);
         REG_DEST_X:         csr_prdata = CSR_DATA_W'(dest_x_ff);
         REG_DEST_Y:         csr_prdata = CSR_DATA_W'(dest_y_ff);
         REG_SCREEN_WIDTH:   csr_prdata = CSR_DATA_W'(screen_width_ff);
         REG_SCREEN_HEIGHT:  csr_prdata = CSR_DATA_W'(screen_height_ff);
         REG_ROW_PITCH:      csr_prdata = CSR_DATA_W'(row_pitch_ff);
         REG_CHANNEL_LAYOUT: csr_prdata = CSR_DATA_W'(channel_layout_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline flow: stage A (placed, clipped, packed) then the output register.
   // A stage may load when it is empty or its content moves on this cycle.
   // ---------------------------------------------------------------------
   logic a_valid_ff;
   logic rsp_valid_ff;
   logic out_load;
   logic a_load;
   logic req_accept;

   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign a_load     = !a_valid_ff || out_load;
   assign req_stall  = !a_load;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Placement counters and clipping
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;
   logic [DIM_W-1:0] col_cur;
   logic [DIM_W-1:0] row_cur;
   logic             dims_zero;
   logic             row_end;
   logic             last_stored;
   logic [XY_W-1:0]  fx;
   logic [XY_W-1:0]  fy;
   logic             keep;

   // Saturate oversize dimensions.
   assign width_eff  = (image_width_ff > DIM_W'(MAX_DIMENSION)) ?
                       DIM_W'(MAX_DIMENSION) : image_width_ff;
   assign height_eff = (image_height_ff > DIM_W'(MAX_DIMENSION)) ?
                       DIM_W'(MAX_DIMENSION) : image_height_ff;
   assign dims_zero  = (width_eff == '0) || (height_eff == '0);

   assign col_cur = req_first_pixel ? '0 : col_ff;
   assign row_cur = req_first_pixel ? '0 : row_ff;

   // A counter at or past its limit ends the row or the bitmap.
   assign row_end     = ({1'b0, col_cur} + 1'b1) >= {1'b0, width_eff};
   assign last_stored = row_end && (({1'b0, row_cur} + 1'b1) >= {1'b0, height_eff});

   // Screen position; the stored row is flipped so stored row 0 is the bottom.
   assign fx = {{2{dest_x_ff[COORD_W-1]}}, dest_x_ff} + XY_W'(col_cur);
   assign fy = {{2{dest_y_ff[COORD_W-1]}}, dest_y_ff}
             + XY_W'(height_eff) - XY_W'(1) - XY_W'(row_cur);

   assign keep = !dims_zero
              && !fx[XY_W-1] && (fx < XY_W'(screen_width_ff))
              && !fy[XY_W-1] && (fy < XY_W'(screen_height_ff));

   always_comb begin
      if (dims_zero || last_stored) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_cur + 1'b1;
      end else begin
         col_in = col_cur + 1'b1;
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: hold the clipped position and the packed word
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0] pixel_word;

   bbcp_pack u_pack (
      .red_byte       (req_red_byte),
      .green_byte     (req_green_byte),
      .blue_byte      (req_blue_byte),
      .channel_layout (channel_layout_ff),
      .packed_pixel   (pixel_word)
   );

   logic [SCREEN_W-1:0] a_fx_ff;
   logic [SCREEN_W-1:0] a_fy_ff;
   logic                a_last_ff;
   logic [WORD_W-1:0]   a_pixel_ff;

   // A kept pixel lies inside the screen, so both coordinates fit SCREEN_W bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= req_accept && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_fx_ff    <= fx[SCREEN_W-1:0];
         a_fy_ff    <= fy[SCREEN_W-1:0];
         a_last_ff  <= last_stored;
         a_pixel_ff <= pixel_word;
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: row multiply plus column offset
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] row_bytes;
   logic [WORD_W-1:0] offset;

   assign row_bytes = PROD_W'(a_fy_ff) * PROD_W'(row_pitch_ff);
   assign offset    = WORD_W'(row_bytes) + (WORD_W'(a_fx_ff) << BPP_SHIFT);

   logic [WORD_W-1:0] rsp_byte_offset_ff;
   logic [WORD_W-1:0] rsp_packed_pixel_ff;
   logic              rsp_last_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_byte_offset_ff  <= offset;
         rsp_packed_pixel_ff <= a_pixel_ff;
         rsp_last_pixel_ff   <= a_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_offset  = rsp_byte_offset_ff;
   assign rsp_packed_pixel = rsp_packed_pixel_ff;
   assign rsp_last_pixel   = rsp_last_pixel_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // Counters never pass the largest dimension.
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < DIM_W'(MAX_DIMENSION)) && (row_ff < DIM_W'(MAX_DIMENSION)))
      else $error("placement counter beyond maximum dimension");

   // An empty bitmap leaves both counters at zero.
   a_empty_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && dims_zero) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters moved for an empty bitmap");

   // Input is held back only when both stages are full and the output stalls.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // A full stage A with a free output slot must reach the output next cycle.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && out_load) |=> rsp_valid_ff)
      else $error("pixel lost between stage A and output");

endmodule
